// ===== design/jacs_pkg.sv =====
// ----------------------------------------------------------------------------
// jacs_pkg
// Shared types and constants of the joystick axis calibrate and scale unit.
// ----------------------------------------------------------------------------
package jacs_pkg;

   localparam int LANES     = 4;
   localparam int SAMPLE_W  = 12;
   localparam int SCALE_W   = 8;
   localparam int FAULT_W   = LANES;
   localparam int DIV_STEPS = 9;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [SCALE_W-2:0] SAT_MAG = 7'd127;

   localparam logic [1:0] KIND_START   = 2'd0;
   localparam logic [1:0] KIND_CAL     = 2'd1;
   localparam logic [1:0] KIND_CONVERT = 2'd2;

   typedef struct packed {
      logic [1:0]          kind;
      logic [SAMPLE_W-1:0] sample_a;
      logic [SAMPLE_W-1:0] sample_b;
      logic [SAMPLE_W-1:0] sample_c;
      logic [SAMPLE_W-1:0] sample_d;
   } req_word_type;

   typedef struct packed {
      logic signed [SCALE_W-1:0] scaled_a;
      logic signed [SCALE_W-1:0] scaled_b;
      logic signed [SCALE_W-1:0] scaled_c;
      logic signed [SCALE_W-1:0] scaled_d;
      logic [FAULT_W-1:0]        range_fault;
   } rsp_word_type;

   typedef struct packed {
      logic clear;
      logic widen;
      logic load;
      logic setup;
      logic step;
   } lane_ctrl_type;

   typedef struct packed {
      logic signed [SCALE_W-1:0] scaled;
      logic                      fault;
   } lane_res_type;

endpackage

// ===== design/jacs_lane.sv =====
// ----------------------------------------------------------------------------
// jacs_lane
// One axis: min/max marks, offset and scale setup, shift-subtract divider.
// ----------------------------------------------------------------------------
module jacs_lane #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  jacs_pkg::lane_ctrl_type       ctrl,
   input  logic [jacs_pkg::SAMPLE_W-1:0] sample,
   output jacs_pkg::lane_res_type        res
);

   localparam int SW = SAMPLE_BITS;
   localparam int WW = SW + 10;
   localparam int QW = jacs_pkg::DIV_STEPS;

   logic [SW-1:0] s;
   logic [SW-1:0] low_ff, low_in, high_ff, high_in, x_ff;
   logic [WW-1:0] rem_ff, dvs_ff;
   logic [QW-1:0] quo_ff;
   logic          neg_ff, fault_ff;

   logic signed [SW:0]   r_s, d_s;
   logic signed [SW+2:0] t_s;
   logic signed [WW-1:0] num_s;
   logic [WW-1:0]        mag, den_sh;
   logic [SW:0]          den;
   logic                 fault, ge;
   logic [jacs_pkg::SCALE_W-2:0] mag_q;

   generate
      if (SW >= jacs_pkg::SAMPLE_W) begin : g_wide
         assign s = SW'(sample);
      end else begin : g_narrow
         assign s = sample[SW-1:0];
      end
   endgenerate

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (ctrl.clear) begin
         low_in  = '1;
         high_in = '0;
      end else if (ctrl.widen) begin
         if (s < low_ff) low_in = s;
         if (s > high_ff) high_in = s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   // numerator 127*(2*(x-min)-range), denominator 2*range
   always_comb begin
      r_s    = $signed({1'b0, high_ff}) - $signed({1'b0, low_ff});
      d_s    = $signed({1'b0, x_ff}) - $signed({1'b0, low_ff});
      t_s    = ((SW+3)'(d_s) <<< 1) - (SW+3)'(r_s);
      num_s  = (WW'(t_s) <<< 7) - WW'(t_s);
      mag    = num_s[WW-1] ? $unsigned(-num_s) : $unsigned(num_s);
      den    = {r_s[SW-1:0], 1'b0};
      den_sh = WW'({den, (QW-1)'(0)});
      fault  = r_s[SW] || (r_s == '0);
   end

   assign ge = (rem_ff >= dvs_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load) x_ff <= s;
      if (ctrl.setup) begin
         rem_ff   <= mag;
         dvs_ff   <= den_sh;
         quo_ff   <= '0;
         neg_ff   <= num_s[WW-1];
         fault_ff <= fault;
      end else if (ctrl.step) begin
         if (ge) rem_ff <= rem_ff - dvs_ff;
         quo_ff <= {quo_ff[QW-2:0], ge};
         dvs_ff <= dvs_ff >> 1;
      end
   end

   // quotient magnitude saturates at 127, sign gives truncation toward zero
   always_comb begin
      mag_q = (quo_ff > QW'(jacs_pkg::SAT_MAG)) ? jacs_pkg::SAT_MAG
                                                 : quo_ff[jacs_pkg::SCALE_W-2:0];
      res.fault = fault_ff;
      if (fault_ff) begin
         res.scaled = '0;
      end else if (neg_ff) begin
         res.scaled = -$signed({1'b0, mag_q});
      end else begin
         res.scaled = $signed({1'b0, mag_q});
      end
   end

endmodule

// ===== design/jacs_merge.sv =====
// ----------------------------------------------------------------------------
// jacs_merge
// Gathers the lane results into one response word and holds it for output.
// ----------------------------------------------------------------------------
module jacs_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   capture,
   input  jacs_pkg::lane_res_type res [jacs_pkg::LANES],
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output jacs_pkg::rsp_word_type rsp_data,
   output logic                   out_free
);

   logic                   valid_ff, valid_in;
   jacs_pkg::rsp_word_type data_ff, data_in;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (capture) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
      data_in.scaled_a    = res[0].scaled;
      data_in.scaled_b    = res[1].scaled;
      data_in.scaled_c    = res[2].scaled;
      data_in.scaled_d    = res[3].scaled;
      data_in.range_fault = {res[3].fault, res[2].fault, res[1].fault, res[0].fault};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== design/joystick_axis_calibrate_scale_unit.sv =====
// ----------------------------------------------------------------------------
// joystick_axis_calibrate_scale_unit
// Min/max calibration and signed 8-bit normalization of joystick axes.
// ----------------------------------------------------------------------------
// req_ channel: one word carries a kind code and one sample per axis.
//   start word clears the marks (min to full scale, max to 0), calibration
//   word widens them; neither gives a response.
// convert word: every axis lane works in parallel and one rsp_ word comes
//   back with four scaled positions and a range fault bit per axis.
// convert sequence: after the convert word is taken, the lanes pass through
//   one setup step, nine shift-subtract steps of the lane divider and one
//   capture step, after which rsp_valid rises; req_stall is high from
//   acceptance until capture, and capture waits while the output is held.
// the output register is separate from the lanes: a new word is taken
//   while a response waits; when rsp_stall holds a response, a later
//   convert word finishes and waits in its lanes until the register frees.
// reset clears both marks of every axis to 0, so a convert before any
//   calibration reports a range fault on every axis.
// ----------------------------------------------------------------------------
module joystick_axis_calibrate_scale_unit #(
   parameter int AXES        = 4,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  jacs_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output jacs_pkg::rsp_word_type rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_PUSH  = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [jacs_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         accept, capture, out_free;
   jacs_pkg::lane_ctrl_type      ctrl;
   jacs_pkg::lane_res_type       res [jacs_pkg::LANES];
   logic [jacs_pkg::SAMPLE_W-1:0] samples [jacs_pkg::LANES];

   assign samples[0] = req_data.sample_a;
   assign samples[1] = req_data.sample_b;
   assign samples[2] = req_data.sample_c;
   assign samples[3] = req_data.sample_d;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign capture   = (state_ff == ST_PUSH) && out_free;

   always_comb begin
      ctrl.clear = accept && (req_data.kind == jacs_pkg::KIND_START);
      ctrl.widen = accept && (req_data.kind == jacs_pkg::KIND_CAL);
      ctrl.load  = accept && (req_data.kind == jacs_pkg::KIND_CONVERT);
      ctrl.setup = (state_ff == ST_SETUP);
      ctrl.step  = (state_ff == ST_DIV);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctrl.load) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == jacs_pkg::CNT_W'(jacs_pkg::DIV_STEPS - 1)) state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   genvar i;
   generate
      for (i = 0; i < jacs_pkg::LANES; i++) begin : g_lane
         if (i < AXES) begin : g_on
            jacs_lane #(
               .SAMPLE_BITS(SAMPLE_BITS)
            ) u_lane (
               .clock (clock),
               .reset (reset),
               .ctrl  (ctrl),
               .sample(samples[i]),
               .res   (res[i])
            );
         end else begin : g_off
            assign res[i] = '0;
         end
      end
   endgenerate

   jacs_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .capture  (capture),
      .res      (res),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .out_free (out_free)
   );

   a_convert_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.kind == jacs_pkg::KIND_CONVERT) |=> state_ff == ST_SETUP)
      else $error("convert word did not start the lanes");

   a_no_rsp_for_cal: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.kind != jacs_pkg::KIND_CONVERT && !rsp_valid) |=> !rsp_valid)
      else $error("response without a convert word");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.range_fault[0] && rsp_data.scaled_a != 0))
      else $error("faulted axis gave a nonzero position");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> cnt_ff < jacs_pkg::CNT_W'(jacs_pkg::DIV_STEPS))
      else $error("divider step count overran");

endmodule

// ===== bench/joystick_axis_calibrate_scale_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_axis_calibrate_scale_unit_test
// Drives start, calibration, convert and ignored words into the unit, keeps
// its own copy of the per-axis min/max marks, predicts every convert
// response and checks each returned word field by field. Random idling on
// both sides, one long response hold-off and drain pauses between phases.
// ----------------------------------------------------------------------------
module joystick_axis_calibrate_scale_unit_test;

   localparam logic [1:0]                    KIND_IGNORED = 2'd3;
   localparam logic [jacs_pkg::SAMPLE_W-1:0] FULL_SCALE   = '1;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 24;
   localparam int CYCLE_LIMIT = 200000;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   jacs_pkg::req_word_type req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   jacs_pkg::rsp_word_type rsp_data;

   jacs_pkg::req_word_type req_backlog[$];
   jacs_pkg::rsp_word_type scaled_expect[$];

   logic [jacs_pkg::SAMPLE_W-1:0] cal_low[jacs_pkg::LANES];
   logic [jacs_pkg::SAMPLE_W-1:0] cal_high[jacs_pkg::LANES];

   int send_gap_pct  = 0;
   int rsp_hold_pct  = 0;
   int hold_asks     = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int error_count   = 0;
   int word_count    = 0;
   int cycle_count   = 0;

   joystick_axis_calibrate_scale_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // axis scaling and mark tracking
   // ------------------------------------------------------------------------
   function automatic logic signed [jacs_pkg::SCALE_W-1:0] scale_axis(
      input  logic [jacs_pkg::SAMPLE_W-1:0] x,
      input  logic [jacs_pkg::SAMPLE_W-1:0] lo,
      input  logic [jacs_pkg::SAMPLE_W-1:0] hi,
      output logic                          fault
   );
      int span;
      int num;
      int q;
      span = int'(hi) - int'(lo);
      if (span <= 0) begin
         fault = 1'b1;
         return '0;
      end
      fault = 1'b0;
      num = 127 * (2 * (int'(x) - int'(lo)) - span);
      // int division truncates toward zero
      q = num / (2 * span);
      if (q > int'(jacs_pkg::SAT_MAG)) q = int'(jacs_pkg::SAT_MAG);
      if (q < -int'(jacs_pkg::SAT_MAG)) q = -int'(jacs_pkg::SAT_MAG);
      return q[jacs_pkg::SCALE_W-1:0];
   endfunction

   task automatic fold_in_word(input jacs_pkg::req_word_type w);
      logic [jacs_pkg::SAMPLE_W-1:0]       x[jacs_pkg::LANES];
      logic signed [jacs_pkg::SCALE_W-1:0] pos[jacs_pkg::LANES];
      logic [jacs_pkg::FAULT_W-1:0]        flt;
      jacs_pkg::rsp_word_type              r;
      x[0] = w.sample_a;
      x[1] = w.sample_b;
      x[2] = w.sample_c;
      x[3] = w.sample_d;
      case (w.kind)
         jacs_pkg::KIND_START: begin
            for (int i = 0; i < jacs_pkg::LANES; i++) begin
               cal_low[i]  = FULL_SCALE;
               cal_high[i] = '0;
            end
         end
         jacs_pkg::KIND_CAL: begin
            for (int i = 0; i < jacs_pkg::LANES; i++) begin
               if (x[i] < cal_low[i]) cal_low[i] = x[i];
               if (x[i] > cal_high[i]) cal_high[i] = x[i];
            end
         end
         jacs_pkg::KIND_CONVERT: begin
            for (int i = 0; i < jacs_pkg::LANES; i++)
               pos[i] = scale_axis(x[i], cal_low[i], cal_high[i], flt[i]);
            r.scaled_a    = pos[0];
            r.scaled_b    = pos[1];
            r.scaled_c    = pos[2];
            r.scaled_d    = pos[3];
            r.range_fault = flt;
            scaled_expect.push_back(r);
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         for (int i = 0; i < jacs_pkg::LANES; i++) begin
            cal_low[i]  = '0;
            cal_high[i] = '0;
         end
      end else begin
         if (req_valid && !req_stall)
            fold_in_word(req_data);
         if (req_valid && req_stall) begin
            // stalled word stays as it is
         end else if (req_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_data  <= req_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor and response stall
   // ------------------------------------------------------------------------
   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      jacs_pkg::rsp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (scaled_expect.size() == 0) begin
               $error("response word %h with none expected", rsp_data);
               error_count++;
            end else begin
               want = scaled_expect.pop_front();
               check_field("scaled_a", int'(want.scaled_a), int'(rsp_data.scaled_a));
               check_field("scaled_b", int'(want.scaled_b), int'(rsp_data.scaled_b));
               check_field("scaled_c", int'(want.scaled_c), int'(rsp_data.scaled_c));
               check_field("scaled_d", int'(want.scaled_d), int'(rsp_data.scaled_d));
               check_field("range_fault", int'(want.range_fault),
                           int'(rsp_data.range_fault));
            end
         end
         if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL joystick_axis_calibrate_scale_unit");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   function automatic logic [jacs_pkg::SAMPLE_W-1:0] any_sample();
      return jacs_pkg::SAMPLE_W'($urandom_range(int'(FULL_SCALE)));
   endfunction

   function automatic logic [jacs_pkg::SAMPLE_W-1:0] near(input int center,
                                                          input int spread);
      int v;
      v = center + int'($urandom_range(2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > int'(FULL_SCALE)) v = int'(FULL_SCALE);
      return jacs_pkg::SAMPLE_W'(v);
   endfunction

   task automatic push_word(input logic [1:0]                    kind,
                            input logic [jacs_pkg::SAMPLE_W-1:0] a,
                            input logic [jacs_pkg::SAMPLE_W-1:0] b,
                            input logic [jacs_pkg::SAMPLE_W-1:0] c,
                            input logic [jacs_pkg::SAMPLE_W-1:0] d);
      jacs_pkg::req_word_type w;
      w.kind     = kind;
      w.sample_a = a;
      w.sample_b = b;
      w.sample_c = c;
      w.sample_d = d;
      req_backlog.push_back(w);
      if (kind != KIND_IGNORED) word_count++;
   endtask

   task automatic push_noise();
      push_word(2'($urandom_range(3)), any_sample(), any_sample(), any_sample(),
                any_sample());
   endtask

   // one calibration session: start, samples around a per-axis center, converts, or (pick 0) only noise words
   task automatic push_session();
      int pick;
      int ncal;
      int nconv;
      int center[jacs_pkg::LANES];
      int spread[jacs_pkg::LANES];
      logic [jacs_pkg::SAMPLE_W-1:0] s[jacs_pkg::LANES];
      pick = $urandom_range(9);
      for (int i = 0; i < jacs_pkg::LANES; i++) begin
         center[i] = $urandom_range(int'(FULL_SCALE));
         spread[i] = 1 << $urandom_range(jacs_pkg::SAMPLE_W - 1);
      end
      if (pick == 0) begin
         repeat ($urandom_range(1, 4)) push_noise();
         return;
      end
      // pick 1 keeps widening the old marks, pick 2 converts right after start
      if (pick != 1) push_word(jacs_pkg::KIND_START, any_sample(), any_sample(),
                               any_sample(), any_sample());
      ncal = (pick == 2) ? 0 : $urandom_range(1, 6);
      repeat (ncal) begin
         for (int i = 0; i < jacs_pkg::LANES; i++) s[i] = near(center[i], spread[i]);
         push_word(jacs_pkg::KIND_CAL, s[0], s[1], s[2], s[3]);
         if ($urandom_range(7) == 0)
            push_word(KIND_IGNORED, any_sample(), any_sample(), any_sample(), any_sample());
      end
      nconv = $urandom_range(1, 6);
      repeat (nconv) begin
         for (int i = 0; i < jacs_pkg::LANES; i++)
            s[i] = ($urandom_range(4) == 0) ? any_sample() : near(center[i], 2 * spread[i]);
         push_word(jacs_pkg::KIND_CONVERT, s[0], s[1], s[2], s[3]);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || scaled_expect.size() != 0);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_gap_pct = 9;
      rsp_hold_pct = 69;

      // marks still at reset: every axis faults
      push_word(jacs_pkg::KIND_CONVERT, 12'd0, 12'd4095, 12'd2048, 12'd1);
      push_word(KIND_IGNORED, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
      push_word(jacs_pkg::KIND_START, 12'd4095, 12'd0, 12'd4095, 12'd0);
      // cleared marks give a negative range
      push_word(jacs_pkg::KIND_CONVERT, 12'd4095, 12'd0, 12'd2048, 12'd4095);
      push_word(jacs_pkg::KIND_CAL, 12'd0, 12'd4095, 12'd2048, 12'd1);
      // one sample only: zero range
      push_word(jacs_pkg::KIND_CONVERT, 12'd0, 12'd4095, 12'd2048, 12'd1);
      push_word(jacs_pkg::KIND_CAL, 12'd4095, 12'd0, 12'd2049, 12'd4094);
      push_word(jacs_pkg::KIND_CONVERT, 12'd0, 12'd0, 12'd0, 12'd0);
      push_word(jacs_pkg::KIND_CONVERT, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
      push_word(jacs_pkg::KIND_CONVERT, 12'd2048, 12'd2047, 12'd2049, 12'd1);
      push_word(jacs_pkg::KIND_CONVERT, 12'hAAA, 12'h555, 12'hAAA, 12'h555);
      // ignored word must leave the marks alone
      push_word(KIND_IGNORED, 12'd0, 12'd0, 12'd0, 12'd0);
      push_word(jacs_pkg::KIND_CONVERT, 12'h555, 12'hAAA, 12'd2048, 12'd4094);
      push_word(jacs_pkg::KIND_START, 12'd0, 12'd0, 12'd0, 12'd0);
      push_word(jacs_pkg::KIND_CAL, 12'd1000, 12'd1000, 12'd1000, 12'd1000);
      push_word(jacs_pkg::KIND_CAL, 12'd1010, 12'd1020, 12'd1001, 12'd1000);
      // far outside a narrow span: saturation (axis d has zero range and faults)
      push_word(jacs_pkg::KIND_CONVERT, 12'd0, 12'd4095, 12'd0, 12'd1000);
      push_word(jacs_pkg::KIND_CONVERT, 12'd4095, 12'd0, 12'd4095, 12'd4095);
      push_word(jacs_pkg::KIND_CONVERT, 12'd1005, 12'd1010, 12'd1001, 12'd999);
      wait_drained();

      // long response hold-off while converts keep coming
      push_word(jacs_pkg::KIND_START, 12'd0, 12'd0, 12'd0, 12'd0);
      repeat (3)
         push_word(jacs_pkg::KIND_CAL, any_sample(), any_sample(), any_sample(),
                   any_sample());
      repeat (24)
         push_word(jacs_pkg::KIND_CONVERT, any_sample(), any_sample(), any_sample(),
                   any_sample());
      hold_asks++;

      while (word_count < 220) begin
         push_session();
         if (req_backlog.size() > 40) wait_drained();
      end
      wait_drained();

      send_gap_pct = 69;
      rsp_hold_pct = 9;
      while (word_count < 420) begin
         push_session();
         if (req_backlog.size() > 40) wait_drained();
      end
      wait_drained();

      send_gap_pct = 0;
      rsp_hold_pct = 0;
      while (word_count < 620) begin
         push_session();
         if (req_backlog.size() > 40) wait_drained();
      end
      wait_drained();

      // start and calibration words give no response; let the last one finish
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && scaled_expect.size() == 0)
         $display("PASS joystick_axis_calibrate_scale_unit");
      else
         $display("FAIL joystick_axis_calibrate_scale_unit");
      $finish;
   end

endmodule

// ===== sim.f =====
design/jacs_pkg.sv
design/jacs_lane.sv
design/jacs_merge.sv
design/joystick_axis_calibrate_scale_unit.sv
bench/joystick_axis_calibrate_scale_unit_test.sv
